/* hdl/acee_pkg.sv */
package acee_pkg;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBRK = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam int unsigned N_ATTR   = 5;
  localparam int unsigned MAX_BEAT = 47;

  localparam logic [1:0] DP_HUND = 2'd0;
  localparam logic [1:0] DP_TENS = 2'd1;
  localparam logic [1:0] DP_ONES = 2'd2;

  // Attribute order on the wire: hidden, inverse, blink, underline, bold.
  localparam logic [3:0] ATTR_CODE [N_ATTR] = '{4'd8, 4'd7, 4'd5, 4'd4, 4'd1};

  typedef struct packed {
    logic [1:0] hund;
    logic [6:0] rem;
  } part_t;

  typedef struct packed {
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
    logic [1:0] start;
  } dec_t;

  typedef struct packed {
    part_t             row;
    part_t             col;
    part_t             bg;
    part_t             fg;
    logic [N_ATTR-1:0] attr;
    logic [7:0]        glyph;
  } half_t;

  typedef struct packed {
    dec_t              row;
    dec_t              col;
    dec_t              bg;
    dec_t              fg;
    logic [N_ATTR-1:0] attr;
    logic [7:0]        glyph;
  } cell_t;

  function automatic part_t split_hund(input logic [8:0] v);
    part_t p;
    if (v >= 9'd200) begin
      p.hund = 2'd2;
      p.rem  = 7'(v - 9'd200);
    end else if (v >= 9'd100) begin
      p.hund = 2'd1;
      p.rem  = 7'(v - 9'd100);
    end else begin
      p.hund = 2'd0;
      p.rem  = v[6:0];
    end
    return p;
  endfunction

  // Tens by reciprocal multiplication, exact for remainders below 100.
  function automatic dec_t split_tens(input part_t p);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tx10;
    dec_t        d;
    prod  = {8'd0, p.rem} * 15'd205;
    tens  = prod[14:11];
    tx10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
    d.d2  = {2'b00, p.hund};
    d.d1  = tens;
    d.d0  = 4'(p.rem - tx10);
    if (p.hund != 2'd0) begin
      d.start = DP_HUND;
    end else if (tens != 4'd0) begin
      d.start = DP_TENS;
    end else begin
      d.start = DP_ONES;
    end
    return d;
  endfunction

  function automatic logic [7:0] dec_char(input dec_t d, input logic [1:0] sel);
    logic [3:0] dig;
    case (sel)
      DP_HUND: dig = d.d2;
      DP_TENS: dig = d.d1;
      default: dig = d.d0;
    endcase
    return CH_ZERO | {4'd0, dig};
  endfunction

  function automatic logic [7:0] attr_char(input logic [N_ATTR-1:0] onehot);
    logic [3:0] code;
    code = 4'd0;
    for (int i = 0; i < N_ATTR; i++) begin
      if (onehot[i]) begin
        code = code | ATTR_CODE[i];
      end
    end
    return CH_ZERO | {4'd0, code};
  endfunction

endpackage

/* hdl/acee_split.sv */
module acee_split (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  logic [7:0]            up_row,
  input  logic [7:0]            up_column,
  input  logic [7:0]            up_back_colour,
  input  logic [7:0]            up_fore_colour,
  input  logic [acee_pkg::N_ATTR-1:0] up_attr,
  input  logic [7:0]            up_glyph,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output acee_pkg::cell_t       dn_cell
);

  logic              s1_valid_r;
  acee_pkg::half_t   s1_r;
  acee_pkg::half_t   s1_nxt;
  logic              s2_valid_r;
  acee_pkg::cell_t   s2_r;
  acee_pkg::cell_t   s2_nxt;
  logic              s1_take;
  logic              s2_take;

  assign s2_take  = !s2_valid_r || !dn_stall;
  assign s1_take  = !s1_valid_r || s2_take;
  assign up_stall = !s1_take;

  always_comb begin
    s1_nxt.row   = acee_pkg::split_hund({1'b0, up_row} + 9'd1);
    s1_nxt.col   = acee_pkg::split_hund({1'b0, up_column} + 9'd1);
    s1_nxt.bg    = acee_pkg::split_hund({1'b0, up_back_colour});
    s1_nxt.fg    = acee_pkg::split_hund({1'b0, up_fore_colour});
    s1_nxt.attr  = up_attr;
    s1_nxt.glyph = up_glyph;
  end

  always_comb begin
    s2_nxt.row   = acee_pkg::split_tens(s1_r.row);
    s2_nxt.col   = acee_pkg::split_tens(s1_r.col);
    s2_nxt.bg    = acee_pkg::split_tens(s1_r.bg);
    s2_nxt.fg    = acee_pkg::split_tens(s1_r.fg);
    s2_nxt.attr  = s1_r.attr;
    s2_nxt.glyph = s1_r.glyph;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_r <= up_valid;
        s1_r       <= s1_nxt;
      end
      if (s2_take) begin
        s2_valid_r <= s1_valid_r;
        s2_r       <= s2_nxt;
      end
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_cell  = s2_r;

endmodule

/* hdl/acee_seq.sv */
module acee_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cell_valid,
  output logic            cell_stall,
  input  acee_pkg::cell_t cell_in,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  typedef enum logic [4:0] {
    ST_POS_ESC, ST_POS_BRK, ST_ROW, ST_SEMI, ST_COL, ST_POS_H,
    ST_RST_ESC, ST_RST_BRK, ST_RST_0, ST_RST_M,
    ST_BG_ESC, ST_BG_BRK, ST_BG, ST_BG_M,
    ST_FG_ESC, ST_FG_BRK, ST_FG, ST_FG_M,
    ST_ATT_ESC, ST_ATT_BRK, ST_ATT_DIG, ST_ATT_M,
    ST_GLYPH
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic                        busy_r;
  acee_pkg::cell_t             cell_r;
  logic [1:0]                  dp_r;
  logic [1:0]                  dp_nxt;
  logic [acee_pkg::N_ATTR-1:0] pend_r;
  logic [acee_pkg::N_ATTR-1:0] pend_nxt;
  logic [acee_pkg::N_ATTR-1:0] first;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;
  logic [7:0]                  byte_cur;
  logic                        last_cur;
  logic                        out_free;
  logic                        take;

  assign out_free   = !out_valid_r || !out_stall;
  assign take       = !busy_r || (out_free && (state_r == ST_GLYPH));
  assign cell_stall = !take;
  assign first      = pend_r & (~pend_r + 1'b1);

  always_comb begin
    byte_cur  = acee_pkg::CH_ESC;
    last_cur  = 1'b0;
    state_nxt = state_r;
    dp_nxt    = dp_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      ST_POS_ESC: state_nxt = ST_POS_BRK;
      ST_POS_BRK: begin
        byte_cur  = acee_pkg::CH_LBRK;
        state_nxt = ST_ROW;
        dp_nxt    = cell_r.row.start;
      end
      ST_ROW: begin
        byte_cur = acee_pkg::dec_char(cell_r.row, dp_r);
        if (dp_r == acee_pkg::DP_ONES) begin
          state_nxt = ST_SEMI;
        end else begin
          dp_nxt = dp_r + 2'd1;
        end
      end
      ST_SEMI: begin
        byte_cur  = acee_pkg::CH_SEMI;
        state_nxt = ST_COL;
        dp_nxt    = cell_r.col.start;
      end
      ST_COL: begin
        byte_cur = acee_pkg::dec_char(cell_r.col, dp_r);
        if (dp_r == acee_pkg::DP_ONES) begin
          state_nxt = ST_POS_H;
        end else begin
          dp_nxt = dp_r + 2'd1;
        end
      end
      ST_POS_H: begin
        byte_cur  = acee_pkg::CH_H;
        state_nxt = ST_RST_ESC;
      end
      ST_RST_ESC: state_nxt = ST_RST_BRK;
      ST_RST_BRK: begin
        byte_cur  = acee_pkg::CH_LBRK;
        state_nxt = ST_RST_0;
      end
      ST_RST_0: begin
        byte_cur  = acee_pkg::CH_ZERO;
        state_nxt = ST_RST_M;
      end
      ST_RST_M: begin
        byte_cur  = acee_pkg::CH_M;
        state_nxt = ST_BG_ESC;
      end
      ST_BG_ESC: state_nxt = ST_BG_BRK;
      ST_BG_BRK: begin
        byte_cur  = acee_pkg::CH_LBRK;
        state_nxt = ST_BG;
        dp_nxt    = cell_r.bg.start;
      end
      ST_BG: begin
        byte_cur = acee_pkg::dec_char(cell_r.bg, dp_r);
        if (dp_r == acee_pkg::DP_ONES) begin
          state_nxt = ST_BG_M;
        end else begin
          dp_nxt = dp_r + 2'd1;
        end
      end
      ST_BG_M: begin
        byte_cur  = acee_pkg::CH_M;
        state_nxt = ST_FG_ESC;
      end
      ST_FG_ESC: state_nxt = ST_FG_BRK;
      ST_FG_BRK: begin
        byte_cur  = acee_pkg::CH_LBRK;
        state_nxt = ST_FG;
        dp_nxt    = cell_r.fg.start;
      end
      ST_FG: begin
        byte_cur = acee_pkg::dec_char(cell_r.fg, dp_r);
        if (dp_r == acee_pkg::DP_ONES) begin
          state_nxt = ST_FG_M;
        end else begin
          dp_nxt = dp_r + 2'd1;
        end
      end
      ST_FG_M: begin
        byte_cur  = acee_pkg::CH_M;
        state_nxt = (pend_r != '0) ? ST_ATT_ESC : ST_GLYPH;
      end
      ST_ATT_ESC: state_nxt = ST_ATT_BRK;
      ST_ATT_BRK: begin
        byte_cur  = acee_pkg::CH_LBRK;
        state_nxt = ST_ATT_DIG;
      end
      ST_ATT_DIG: begin
        byte_cur  = acee_pkg::attr_char(first);
        state_nxt = ST_ATT_M;
      end
      ST_ATT_M: begin
        byte_cur  = acee_pkg::CH_M;
        pend_nxt  = pend_r & ~first;
        state_nxt = ((pend_r & ~first) != '0) ? ST_ATT_ESC : ST_GLYPH;
      end
      ST_GLYPH: begin
        byte_cur  = cell_r.glyph;
        last_cur  = 1'b1;
        state_nxt = ST_POS_ESC;
      end
      default: state_nxt = ST_POS_ESC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_POS_ESC;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= busy_r;
      end
      if (busy_r && out_free) begin
        out_byte_r <= byte_cur;
        out_last_r <= last_cur;
      end
      if (take) begin
        busy_r  <= cell_valid;
        cell_r  <= cell_in;
        pend_r  <= cell_in.attr;
        state_r <= ST_POS_ESC;
      end else if (busy_r && out_free) begin
        state_r <= state_nxt;
        dp_r    <= dp_nxt;
        pend_r  <= pend_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

/* hdl/ansi_cell_escape_encoder_core.sv */
// Turns one text cell into its terminal byte stream: cursor placement, attribute reset,
// background and foreground colour, the requested attributes and then the character,
// which is the only beat with out_last set. The byte serializer writes one byte per cycle
// while out_stall is low; a cell is 19 to 47 bytes depending on its number of digits and
// attribute flags (19 plus one per extra digit plus four per attribute set). An input beat
// is held in split stages s1 and s2 and then in the sequencer's cell register. The next cell
// is taken as the current cell's character byte goes out, so cells follow without a gap.
module ansi_cell_escape_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_row,
  input  logic [7:0] in_column,
  input  logic [7:0] in_back_colour,
  input  logic [7:0] in_fore_colour,
  input  logic       in_hidden,
  input  logic       in_inverse,
  input  logic       in_blink,
  input  logic       in_underline,
  input  logic       in_bold,
  input  logic [7:0] in_glyph,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic            cell_valid;
  logic            cell_stall;
  acee_pkg::cell_t dec_cell;

  acee_split u_split (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (in_valid),
    .up_stall       (in_stall),
    .up_row         (in_row),
    .up_column      (in_column),
    .up_back_colour (in_back_colour),
    .up_fore_colour (in_fore_colour),
    .up_attr        ({in_bold, in_underline, in_blink, in_inverse, in_hidden}),
    .up_glyph       (in_glyph),
    .dn_valid       (cell_valid),
    .dn_stall       (cell_stall),
    .dn_cell        (dec_cell)
  );

  acee_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_in    (dec_cell),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

/* hdl/acee_check.sv */
module acee_check (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);

  logic       after_last_r;
  logic       prev_esc_r;
  logic [5:0] cnt_r;
  logic       out_beat;

  assign out_beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_last_r <= 1'b1;
      prev_esc_r   <= 1'b0;
      cnt_r        <= 6'd0;
    end else if (out_beat) begin
      after_last_r <= out_last;
      prev_esc_r   <= !out_last && (out_byte == acee_pkg::CH_ESC);
      cnt_r        <= out_last ? 6'd0 : cnt_r + 6'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output beat changed");

  a_cell_opens_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && after_last_r |-> out_byte == acee_pkg::CH_ESC && !out_last)
    else $error("cell does not open with ESC");

  a_esc_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && prev_esc_r |-> out_byte == acee_pkg::CH_LBRK)
    else $error("ESC not followed by bracket");

  a_cell_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_r == 6'(acee_pkg::MAX_BEAT - 1) |-> out_last)
    else $error("cell longer than the longest sequence");

endmodule

bind ansi_cell_escape_encoder_core acee_check u_check (.*);
